// File: rtl/core/ipsp_pkg.sv
// ----------------------------------------------------------------------------
// ipsp_pkg
// Shared types and constants of the patch record parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ipsp_pkg;

  localparam int unsigned OffsetW = 24;
  localparam int unsigned SizeW   = 16;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned AddrW   = 25;

  // Offset value that marks the end of the patch ("EOF" in ASCII).
  localparam logic [OffsetW-1:0] END_MARK = 24'h454F46;

  // Header length skipped after reset.
  localparam logic [SizeW-1:0] SKIP_RESET = 16'd5;

  // Default depth of the command queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // One write command handed from the front to the back.
  typedef struct packed {
    logic               end_mark;
    logic [OffsetW-1:0] base;
    logic [SizeW-1:0]   idx;
    logic [SizeW-1:0]   len;
    logic [ByteW-1:0]   fill;
  } cmd_t;

endpackage

`default_nettype wire

// File: rtl/core/ipsp_front.sv
// ----------------------------------------------------------------------------
// ipsp_front
// Byte parser: skips the header, collects record fields, issues commands.
// ----------------------------------------------------------------------------
`default_nettype none

module ipsp_front
  import ipsp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [SizeW-1:0] skip_bytes_i,
  input  wire logic             byte_valid_i,
  output logic                  byte_ready_o,
  input  wire logic [ByteW-1:0] byte_i,
  output logic                  cmd_valid_o,
  input  wire logic             cmd_ready_i,
  output cmd_t                  cmd_o
);

  typedef enum logic [10:0] {
    PH_SKIP  = 11'b000_0000_0001,
    PH_OFF0  = 11'b000_0000_0010,
    PH_OFF1  = 11'b000_0000_0100,
    PH_OFF2  = 11'b000_0000_1000,
    PH_SIZE0 = 11'b000_0001_0000,
    PH_SIZE1 = 11'b000_0010_0000,
    PH_DATA  = 11'b000_0100_0000,
    PH_RUN0  = 11'b000_1000_0000,
    PH_RUN1  = 11'b001_0000_0000,
    PH_FILL  = 11'b010_0000_0000,
    PH_DONE  = 11'b100_0000_0000
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [SizeW-1:0]   lead_q, lead_d;
  logic [OffsetW-1:0] off_q, off_d;
  logic [SizeW-1:0]   size_q, size_d;
  logic [SizeW-1:0]   idx_q, idx_d;
  logic [SizeW-1:0]   run_q, run_d;
  logic               byte_fire;
  logic [SizeW:0]     idx_inc;

  assign byte_ready_o = cmd_ready_i;
  assign byte_fire    = byte_valid_i && byte_ready_o;
  assign idx_inc      = {1'b0, idx_q} + {{SizeW{1'b0}}, 1'b1};

  always_comb begin
    phase_d     = phase_q;
    lead_d      = lead_q;
    off_d       = off_q;
    size_d      = size_q;
    idx_d       = idx_q;
    run_d       = run_q;
    cmd_valid_o = 1'b0;
    cmd_o       = '0;
    if (byte_fire) begin
      unique case (phase_q)
        PH_SKIP: begin
          if (lead_q < skip_bytes_i) begin
            lead_d = lead_q + 16'd1;
          end else begin
            // header done: this byte already opens the first record
            off_d   = {16'h0000, byte_i};
            phase_d = PH_OFF1;
          end
        end
        PH_OFF0: begin
          off_d   = {16'h0000, byte_i};
          phase_d = PH_OFF1;
        end
        PH_OFF1: begin
          off_d   = {off_q[15:0], byte_i};
          phase_d = PH_OFF2;
        end
        PH_OFF2: begin
          off_d = {off_q[15:0], byte_i};
          if ({off_q[15:0], byte_i} == END_MARK) begin
            cmd_valid_o    = 1'b1;
            cmd_o.end_mark = 1'b1;
            phase_d        = PH_DONE;
          end else begin
            phase_d = PH_SIZE0;
          end
        end
        PH_SIZE0: begin
          size_d  = {8'h00, byte_i};
          phase_d = PH_SIZE1;
        end
        PH_SIZE1: begin
          size_d  = {size_q[7:0], byte_i};
          idx_d   = '0;
          phase_d = ({size_q[7:0], byte_i} == '0) ? PH_RUN0 : PH_DATA;
        end
        PH_DATA: begin
          cmd_valid_o = 1'b1;
          cmd_o.base  = off_q;
          cmd_o.idx   = idx_q;
          cmd_o.len   = 16'd1;
          cmd_o.fill  = byte_i;
          idx_d       = idx_inc[SizeW-1:0];
          if (idx_inc >= {1'b0, size_q}) begin
            phase_d = PH_OFF0;
          end
        end
        PH_RUN0: begin
          run_d   = {8'h00, byte_i};
          phase_d = PH_RUN1;
        end
        PH_RUN1: begin
          run_d   = {run_q[7:0], byte_i};
          phase_d = PH_FILL;
        end
        PH_FILL: begin
          phase_d = PH_OFF0;
          if (run_q != '0) begin
            cmd_valid_o = 1'b1;
            cmd_o.base  = off_q;
            cmd_o.len   = run_q;
            cmd_o.fill  = byte_i;
          end
        end
        PH_DONE: begin
          phase_d = PH_DONE;
        end
        default: begin
          phase_d = PH_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SKIP;
      lead_q  <= '0;
    end else begin
      phase_q <= phase_d;
      lead_q  <= lead_d;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q  <= off_d;
    size_q <= size_d;
    idx_q  <= idx_d;
    run_q  <= run_d;
  end

`ifndef SYNTH
  // once the end marker is seen the parser stays finished
  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DONE |=> phase_q == PH_DONE)
    else $error("parser left the finished state");

  // only the end command carries a zero length
  a_zero_len_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_o && cmd_o.len == '0 |-> cmd_o.end_mark)
    else $error("zero-length write command issued");
`endif

endmodule

`default_nettype wire

// File: rtl/core/ipsp_queue.sv
// ----------------------------------------------------------------------------
// ipsp_queue
// Short command FIFO that decouples the parser from the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ipsp_queue
  import ipsp_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  output logic      ready_o,
  input  wire cmd_t cmd_i,
  output logic      valid_o,
  input  wire logic pop_i,
  output cmd_t      cmd_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            slot_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign ready_o = (cnt_q != CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slot_q[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= cmd_i;
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("command queue overfilled");
`endif

endmodule

`default_nettype wire

// File: rtl/core/ipsp_back.sv
// ----------------------------------------------------------------------------
// ipsp_back
// Output stage: forms the target address and holds the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module ipsp_back
  import ipsp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cmd_valid_i,
  output logic                  cmd_pop_o,
  input  wire cmd_t             cmd_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [AddrW-1:0]      run_start_o,
  output logic [SizeW-1:0]      run_length_o,
  output logic [ByteW-1:0]      fill_value_o,
  output logic                  end_seen_o
);

  logic             valid_q;
  logic [AddrW-1:0] start_q, start_d;
  logic [SizeW-1:0] len_q;
  logic [ByteW-1:0] fill_q;
  logic             end_q;

  assign cmd_pop_o = cmd_valid_i && (!valid_q || out_ready_i);
  assign start_d   = {1'b0, cmd_i.base} + {{(AddrW-SizeW){1'b0}}, cmd_i.idx};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      start_q <= start_d;
      len_q   <= cmd_i.len;
      fill_q  <= cmd_i.fill;
      end_q   <= cmd_i.end_mark;
    end
  end

  assign out_valid_o  = valid_q;
  assign run_start_o  = start_q;
  assign run_length_o = len_q;
  assign fill_value_o = fill_q;
  assign end_seen_o   = end_q;

`ifndef SYNTH
  a_end_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && end_q |-> start_q == '0 && len_q == '0 && fill_q == '0)
    else $error("end result carries nonzero fields");
`endif

endmodule

`default_nettype wire

// File: rtl/core/ips_patch_record_parser.sv
// ----------------------------------------------------------------------------
// ips_patch_record_parser
// Turns an IPS patch byte stream into memory write commands.
// ----------------------------------------------------------------------------
// Feed the patch file one byte per word on the patch channel. After the
// configured number of header bytes (skip_bytes, 5 after reset) each record
// is parsed: a nonzero size gives one single-byte write per data byte, a
// zero size gives one run write of count bytes with the fill value (nothing
// for a zero count), and the "EOF" offset gives one end word with end_seen
// set and all other fields zero, after which every byte is dropped until
// reset. The block takes one byte every cycle; a byte is taken in the cycle
// it arrives unless the two-entry command queue is full, which happens only
// while the result port is stalled. Each result passes through the queue, then
// the output register, where the 25-bit address add sits. Write skip_bytes
// only while the stream is idle; it acts at once while the header is still
// being skipped and has no effect later.
// Truncated streams are not detected: the parser simply waits for more bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module ips_patch_record_parser
  import ipsp_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // configuration write channel
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [SizeW-1:0] skip_bytes_i,
  // patch byte channel
  input  wire logic             patch_valid_i,
  output logic                  patch_ready_o,
  input  wire logic [ByteW-1:0] patch_byte_i,
  // result channel
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [AddrW-1:0]      run_start_o,
  output logic [SizeW-1:0]      run_length_o,
  output logic [ByteW-1:0]      fill_value_o,
  output logic                  end_seen_o
);

  logic [SizeW-1:0] skip_q;
  logic             fr_valid, fr_ready;
  cmd_t             fr_cmd;
  logic             q_valid, q_pop;
  cmd_t             q_cmd;

  // Configuration is always taken; hold the header length in a register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q <= SKIP_RESET;
    end else if (cfg_valid_i) begin
      skip_q <= skip_bytes_i;
    end
  end

  // Front: parse bytes and classify them into write commands.
  ipsp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .skip_bytes_i (skip_q),
    .byte_valid_i (patch_valid_i),
    .byte_ready_o (patch_ready_o),
    .byte_i       (patch_byte_i),
    .cmd_valid_o  (fr_valid),
    .cmd_ready_i  (fr_ready),
    .cmd_o        (fr_cmd)
  );

  // Queue: absorb output stalls so the parser can keep taking bytes.
  ipsp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_valid),
    .ready_o (fr_ready),
    .cmd_i   (fr_cmd),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .cmd_o   (q_cmd)
  );

  // Back: add the byte index to the record offset and present the word.
  ipsp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (q_valid),
    .cmd_pop_o    (q_pop),
    .cmd_i        (q_cmd),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .run_start_o  (run_start_o),
    .run_length_o (run_length_o),
    .fill_value_o (fill_value_o),
    .end_seen_o   (end_seen_o)
  );

endmodule

`default_nettype wire

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the IPS patch record parser.
//
// Drives a patch stream through the byte channel with bursty valid and a
// stalling result port. It predicts every write command in a scoreboard
// and compares each result word field by field, in order. The stream starts
// with a header that is cut short by a skip_bytes rewrite. A directed set of
// records follows, then random literal and run records, and the run ends on
// the EOF marker and trailing bytes that must be dropped.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ipsp_pkg::*;

  localparam int unsigned RecordBytes  = 1250;  // record stream length target
  localparam int unsigned PhaseBytes   = 250;   // record bytes between register writes
  localparam int unsigned HoldCycles   = 400;   // one long result-port hold-off
  localparam int unsigned HoldAtBytes  = 600;
  localparam int unsigned SettleCycles = 6;     // covers the two-stage result path
  localparam int unsigned IdleLimit    = 5000;  // cycles with no word moving at all
  localparam int unsigned LeadBytes    = 3;

  // Parser position within the stream.
  typedef enum logic [3:0] {
    ST_LEAD, ST_OFS_HI, ST_OFS_MID, ST_OFS_LO, ST_LEN_HI, ST_LEN_LO,
    ST_LITERAL, ST_CNT_HI, ST_CNT_LO, ST_FILL, ST_FINISHED
  } parse_state_e;

  typedef struct packed {
    logic [AddrW-1:0] start;
    logic [SizeW-1:0] length;
    logic [ByteW-1:0] fill;
    logic             end_mark;
  } write_cmd_t;

  // --------------------------------------------------------------------------
  // Write-command predictor and in-order scoreboard
  // --------------------------------------------------------------------------
  class patch_write_predictor;
    parse_state_e       state;
    logic [SizeW-1:0]   skip;
    logic [SizeW-1:0]   lead;
    logic [OffsetW-1:0] ofs;
    logic [SizeW-1:0]   size;
    logic [SizeW-1:0]   idx;
    logic [SizeW-1:0]   count;
    write_cmd_t         pending_writes[$];
    int unsigned        errors;
    int unsigned        checked;
    int unsigned        literals;
    int unsigned        runs;
    int unsigned        end_marks;

    function new();
      state     = ST_LEAD;
      skip      = SKIP_RESET;
      lead      = '0;
      ofs       = '0;
      size      = '0;
      idx       = '0;
      count     = '0;
      errors    = 0;
      checked   = 0;
      literals  = 0;
      runs      = 0;
      end_marks = 0;
    endfunction

    function void set_skip(logic [SizeW-1:0] value);
      skip = value;
    endfunction

    function void push(logic [AddrW-1:0] start, logic [SizeW-1:0] length,
                       logic [ByteW-1:0] fill, logic end_mark);
      write_cmd_t cmd;
      cmd.start    = start;
      cmd.length   = length;
      cmd.fill     = fill;
      cmd.end_mark = end_mark;
      pending_writes.push_back(cmd);
    endfunction

    // Advance the parser by one accepted byte and queue what it writes.
    function void take_byte(logic [ByteW-1:0] b);
      if (state == ST_LEAD) begin
        if (lead < skip) begin
          lead++;
          return;
        end
        // header done: this very byte opens the first record
        state = ST_OFS_HI;
      end
      case (state)
        ST_OFS_HI: begin
          ofs   = {16'h0, b};
          state = ST_OFS_MID;
        end
        ST_OFS_MID: begin
          ofs   = {ofs[15:0], b};
          state = ST_OFS_LO;
        end
        ST_OFS_LO: begin
          ofs = {ofs[15:0], b};
          if (ofs == END_MARK) begin
            push('0, '0, '0, 1'b1);
            end_marks++;
            state = ST_FINISHED;
          end else begin
            state = ST_LEN_HI;
          end
        end
        ST_LEN_HI: begin
          size  = {8'h0, b};
          state = ST_LEN_LO;
        end
        ST_LEN_LO: begin
          size  = {size[7:0], b};
          idx   = '0;
          state = (size == '0) ? ST_CNT_HI : ST_LITERAL;
        end
        ST_LITERAL: begin
          push({1'b0, ofs} + {9'h0, idx}, 16'd1, b, 1'b0);
          literals++;
          idx++;
          if (idx >= size) state = ST_OFS_HI;
        end
        ST_CNT_HI: begin
          count = {8'h0, b};
          state = ST_CNT_LO;
        end
        ST_CNT_LO: begin
          count = {count[7:0], b};
          state = ST_FILL;
        end
        ST_FILL: begin
          state = ST_OFS_HI;
          if (count != '0) begin
            push({1'b0, ofs}, count, b, 1'b0);
            runs++;
          end
        end
        default: ;  // after the end marker every byte is dropped
      endcase
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compare one result word against the oldest expected write.
    function void match_write(logic [AddrW-1:0] start, logic [SizeW-1:0] length,
                              logic [ByteW-1:0] fill, logic end_mark);
      write_cmd_t want;
      if (pending_writes.size() == 0) begin
        $display("%0t: unexpected write, expected none, actual start=%h len=%h fill=%h end=%b",
                 $time, start, length, fill, end_mark);
        errors++;
        return;
      end
      want = pending_writes.pop_front();
      checked++;
      check_field("run_start",  32'(want.start),    32'(start));
      check_field("run_length", 32'(want.length),   32'(length));
      check_field("fill_value", 32'(want.fill),     32'(fill));
      check_field("end_seen",   32'(want.end_mark), 32'(end_mark));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block under test
  // --------------------------------------------------------------------------
  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             cfg_valid_i   = 1'b0;
  logic [SizeW-1:0] skip_bytes_i  = '0;
  logic             patch_valid_i = 1'b0;
  logic [ByteW-1:0] patch_byte_i  = '0;
  logic             out_ready_i   = 1'b0;
  logic             cfg_ready_o;
  logic             patch_ready_o;
  logic             out_valid_o;
  logic [AddrW-1:0] run_start_o;
  logic [SizeW-1:0] run_length_o;
  logic [ByteW-1:0] fill_value_o;
  logic             end_seen_o;

  patch_write_predictor expected_writes = new();

  int unsigned burst_left   = 0;
  int unsigned bytes_in     = 0;
  int unsigned cfg_writes   = 0;
  int unsigned stuck_cycles = 0;
  bit          hold_req     = 1'b0;
  bit          hold_done    = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  ips_patch_record_parser uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .skip_bytes_i (skip_bytes_i),
    .patch_valid_i(patch_valid_i),
    .patch_ready_o(patch_ready_o),
    .patch_byte_i (patch_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .run_start_o  (run_start_o),
    .run_length_o (run_length_o),
    .fill_value_o (fill_value_o),
    .end_seen_o   (end_seen_o)
  );

  // --------------------------------------------------------------------------
  // Result port: check every word that moves
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      expected_writes.match_write(run_start_o, run_length_o, fill_value_o, end_seen_o);
    end
  end

  // Receiver: switch between stall patterns at random, and once hold off for
  // a long stretch so the command queue fills and the byte channel backs up.
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned tick;
    mode      = 0;
    mode_left = 0;
    tick      = 0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (hold_req && !hold_done) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(3, 0);
          mode_left = $urandom_range(100, 20);
        end
        mode_left--;
        case (mode)
          0:       out_ready_i <= 1'b1;                        // no stalls at all
          1:       out_ready_i <= 1'($urandom_range(1, 0));
          2:       out_ready_i <= ($urandom_range(3, 0) == 0);  // mostly stalled
          default: out_ready_i <= ((tick % 5) != 0);            // fixed rhythm
        endcase
      end
    end
  end

  // Watchdog: end the run if no word moves on any channel for too long.
  always @(posedge clk_i) begin
    if ((patch_valid_i && patch_ready_o) || (cfg_valid_i && cfg_ready_o) ||
        (out_valid_o && out_ready_i)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= IdleLimit) begin
      $display("%0t: no word moved for %0d cycles", $time, IdleLimit);
      $display("FAIL ips_patch_record_parser");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus tasks (all called on a rising edge)
  // --------------------------------------------------------------------------

  // Offer one byte; open a new burst, possibly after a gap, when one runs out.
  task automatic send_byte(input logic [ByteW-1:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(40, 1);
      gap        = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
      if (gap != 0) begin
        patch_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    patch_valid_i <= 1'b1;
    patch_byte_i  <= b;
    forever begin
      @(posedge clk_i);
      if (patch_ready_o) break;
    end
    expected_writes.take_byte(b);
    bytes_in++;
  endtask

  // Drop valid, drain every expected write, then let the pipeline go quiet.
  task automatic settle();
    patch_valid_i <= 1'b0;
    while (expected_writes.pending_writes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_skip(input logic [SizeW-1:0] value);
    cfg_valid_i  <= 1'b1;
    skip_bytes_i <= value;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    cfg_valid_i <= 1'b0;
    expected_writes.set_skip(value);
    cfg_writes++;
  endtask

  task automatic send_record_head(input logic [OffsetW-1:0] ofs, input logic [SizeW-1:0] size);
    send_byte(ofs[23:16]);
    send_byte(ofs[15:8]);
    send_byte(ofs[7:0]);
    send_byte(size[15:8]);
    send_byte(size[7:0]);
  endtask

  task automatic send_literal(input logic [OffsetW-1:0] ofs, input logic [SizeW-1:0] size);
    send_record_head(ofs, size);
    repeat (size) send_byte(ByteW'($urandom_range(255, 0)));
  endtask

  task automatic send_run(input logic [OffsetW-1:0] ofs, input logic [SizeW-1:0] count,
                          input logic [ByteW-1:0] fill);
    send_record_head(ofs, '0);
    send_byte(count[15:8]);
    send_byte(count[7:0]);
    send_byte(fill);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [SizeW-1:0]   phase_skip[4];
    logic [OffsetW-1:0] ofs;
    logic [SizeW-1:0]   size;
    logic [SizeW-1:0]   count;
    int unsigned        pick;
    int unsigned        phase_idx;

    phase_skip[0] = 16'd1;
    phase_skip[1] = 16'hFFFF;
    phase_skip[2] = SizeW'($urandom_range(65535, 0));
    phase_skip[3] = 16'd0;
    phase_idx     = 0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Header: ask for the longest skip, feed a few lead bytes, then cut the
    // header short with a zero skip so the next byte opens a record.
    write_skip(16'hFFFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h45);
    settle();
    write_skip(16'd0);

    // Directed records: address carry into bit 24, near misses of the end
    // marker, a zero-count run that writes nothing, and the widest run.
    send_record_head(24'hFFFFFF, 16'd2);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_record_head(24'h454F47, 16'd1);
    send_byte(8'hA5);
    send_run(24'h454E46, 16'd0, 8'h5A);
    send_run(24'hFFFFFF, 16'hFFFF, 8'hFF);
    send_run(24'h000000, 16'd1, 8'h00);

    // Random records; rewrite skip_bytes between phases (no effect on parsing
    // any more) and trigger the long receiver hold-off once.
    while (bytes_in - LeadBytes < RecordBytes) begin
      if (phase_idx < 4 && bytes_in - LeadBytes >= (phase_idx + 1) * PhaseBytes) begin
        settle();
        write_skip(phase_skip[phase_idx]);
        phase_idx++;
      end
      if (!hold_req && bytes_in - LeadBytes >= HoldAtBytes) hold_req = 1'b1;

      pick = $urandom_range(9, 0);
      case (pick)
        0:       ofs = 24'h000000;
        1:       ofs = 24'hFFFFFF;
        default: ofs = OffsetW'($urandom_range(24'hFFFFFF, 0));
      endcase
      // keep the end marker for the close of the stream
      if (ofs == END_MARK) ofs[0] = ~ofs[0];

      if ($urandom_range(9, 0) < 7) begin
        pick = $urandom_range(19, 0);
        if (pick < 16)      size = SizeW'($urandom_range(8, 1));
        else if (pick < 19) size = SizeW'($urandom_range(40, 9));
        else                size = SizeW'($urandom_range(300, 256));
        send_literal(ofs, size);
      end else begin
        pick = $urandom_range(9, 0);
        if (pick == 0)      count = 16'd0;
        else if (pick == 1) count = 16'hFFFF;
        else                count = SizeW'($urandom_range(65535, 0));
        send_run(ofs, count, ByteW'($urandom_range(255, 0)));
      end
    end

    // Close the patch, then feed trailing bytes (another marker among them)
    // that must all be dropped.
    send_byte(END_MARK[23:16]);
    send_byte(END_MARK[15:8]);
    send_byte(END_MARK[7:0]);
    repeat (20) send_byte(ByteW'($urandom_range(255, 0)));
    send_byte(END_MARK[23:16]);
    send_byte(END_MARK[15:8]);
    send_byte(END_MARK[7:0]);
    repeat (10) send_byte(ByteW'($urandom_range(255, 0)));
    settle();

    $display("Covered %0d patch bytes: %0d literal writes, %0d run writes, %0d end marks.",
             bytes_in, expected_writes.literals, expected_writes.runs,
             expected_writes.end_marks);
    $display("Checked %0d result words; skip_bytes written %0d times; one %0d-cycle hold-off.",
             expected_writes.checked, cfg_writes, HoldCycles);
    if (expected_writes.errors == 0 && expected_writes.pending_writes.size() == 0) begin
      $display("PASS ips_patch_record_parser");
    end else begin
      $display("FAIL ips_patch_record_parser");
    end
    $finish;
  end

endmodule
